// ===== sv/message_framed_byte_fifo_top_defines.svh =====
// Assertion macros for the message-framed byte FIFO.
// Included by the modules that check their own logic; no other dependency.
`ifndef MESSAGE_FRAMED_BYTE_FIFO_TOP_DEFINES_SVH
`define MESSAGE_FRAMED_BYTE_FIFO_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off during reset
`define MFBF_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, clocked on clk, off during reset
`define MFBF_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define MFBF_ASSERT_IMPL(label, pre, post, msg)
`define MFBF_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

// ===== sv/mfbf_pkg.sv =====
// Shared sizes, types, command codes and helpers of the message-framed byte FIFO.
// No dependencies.
package mfbf_pkg;

  localparam int BUFFER_BYTES  = 1024;
  localparam int LENGTH_SLOTS  = 16;
  localparam int MAX_MSG_BYTES = 64;

  // Cursors run 0..BUFFER_BYTES; sums of a cursor and a byte value need one bit more
  localparam int PTR_W  = $clog2(BUFFER_BYTES + 1);
  localparam int SUM_W  = PTR_W + 1;
  localparam int ADDR_W = $clog2(BUFFER_BYTES);
  localparam int SLOT_W = $clog2(LENGTH_SLOTS);
  localparam int WAIT_W = (SLOT_W > 4) ? SLOT_W : 4;

  // A position above this has less than one maximum message before the last byte
  localparam int WRAP_LIMIT = BUFFER_BYTES - 1 - MAX_MSG_BYTES;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [2:0] {
    CMD_STORE        = 3'd0,
    CMD_ADVANCE      = 3'd1,
    CMD_SET_OFFSET   = 3'd2,
    CMD_FINALIZE     = 3'd3,
    CMD_CONFIRM      = 3'd4,
    CMD_READ_HEAD    = 3'd5,
    CMD_RELEASE      = 3'd6,
    CMD_READ_CURRENT = 3'd7
  } cmd_t;

  // Step a length slot around the ring
  function automatic slot_t next_slot(input slot_t s);
    next_slot = (s == SLOT_W'(LENGTH_SLOTS - 1)) ? '0 : slot_t'(s + 1'b1);
  endfunction

  // Finished messages between the read and write slots
  function automatic slot_t slots_waiting(input slot_t ws, input slot_t rs);
    logic [SLOT_W:0] wrapped;
    wrapped = {1'b0, ws} + (SLOT_W+1)'(LENGTH_SLOTS) - {1'b0, rs};
    slots_waiting = (ws >= rs) ? slot_t'(ws - rs) : wrapped[SLOT_W-1:0];
  endfunction

  // True when a cursor at pos must jump back to the buffer start
  function automatic logic near_end(input sum_t pos);
    near_end = pos > sum_t'(WRAP_LIMIT);
  endfunction

endpackage

// ===== sv/mfbf_intf.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on nothing; field widths are fixed by the command format.
interface mfbf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] amount;

  modport source (output valid, cmd, data_byte, byte_index, amount, input ready);
  modport sink   (input valid, cmd, data_byte, byte_index, amount, output ready);
endinterface

interface mfbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic [7:0] head_length;
  logic [7:0] write_space;
  logic [7:0] write_length;
  logic [3:0] messages_waiting;
  logic       error;
  logic       overtake;

  modport source (output valid, data_out, head_length, write_space, write_length,
                  messages_waiting, error, overtake, input ready);
  modport sink   (input valid, data_out, head_length, write_space, write_length,
                  messages_waiting, error, overtake, output ready);
endinterface

// ===== sv/mfbf_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; read data changes only on a read.
module mfbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/message_framed_byte_fifo_top.sv =====
// Message-framed byte FIFO: cursors, length ring, byte store and result register.
// Depends on mfbf_pkg, mfbf_intf, mfbf_ram and message_framed_byte_fifo_top_defines.svh.
//
//   channel   | dir | handshake             | payload
//   ----------+-----+-----------------------+--------------------------------------
//   in_beat   | in  | valid/ready           | cmd, data_byte, byte_index, amount
//   out_beat  | out | valid/ready           | data_out, head_length, write_space,
//             |     |                       | write_length, messages_waiting,
//             |     |                       | error, overtake
//
// One command beat per cycle while the result is not stalled; its result beat passes
// through the middle stage (cursor update and byte store access), then the result register.
// The byte store is one single-port RAM: each command does at most one access.
// A stalled result holds the middle stage, which then holds the input (ready low).
// Reset is synchronous; the byte store needs no clearing.
`include "message_framed_byte_fifo_top_defines.svh"

module message_framed_byte_fifo_top (
  input  logic       clk,
  input  logic       rst_n,
  mfbf_in_if.sink    in_beat,
  mfbf_out_if.source out_beat
);

  // Cursor and slot state
  mfbf_pkg::ptr_t  wp_r, wp_nxt;
  mfbf_pkg::ptr_t  rp_r, rp_nxt;
  mfbf_pkg::ptr_t  ms_r, ms_nxt;
  mfbf_pkg::slot_t ws_r, ws_nxt;
  mfbf_pkg::slot_t rs_r, rs_nxt;
  logic            ov_r, ov_nxt;
  logic [7:0]      wr_len_r, wr_len_nxt;

  // Lengths of closed messages, written at the write slot only
  logic [7:0]      ring_r [mfbf_pkg::LENGTH_SLOTS];
  logic            ring_we;
  logic [7:0]      ring_wdata;

  // Handshake and pipeline
  logic            in_fire;
  logic            in_ready;
  logic            out_take;
  logic            s1_adv;
  logic            s1_valid_r;
  logic            s1_rd_use_r;
  logic            s1_err_r;
  logic            rd_use;
  logic            err;

  // Byte store port
  logic                        ram_we;
  logic                        ram_re;
  logic [mfbf_pkg::ADDR_W-1:0] ram_addr;
  logic [7:0]                  ram_rdata;

  // Derived values
  mfbf_pkg::cmd_t  cmd;
  mfbf_pkg::sum_t  wp_s, rp_s, ms_s;
  mfbf_pkg::sum_t  st_addr, rh_addr, rc_addr;
  mfbf_pkg::sum_t  adv_end, c_end, r_end;
  mfbf_pkg::slot_t wait_cnt;
  logic            ring_full;
  logic [7:0]      head_len;
  logic            do_close;
  mfbf_pkg::ptr_t  room;
  logic [7:0]      space;
  logic [mfbf_pkg::WAIT_W-1:0] wait_ext;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_data_r, out_head_r, out_space_r, out_wlen_r;
  logic [3:0] out_wait_r;
  logic       out_err_r, out_ov_r;

  // Flow control: the middle stage moves when the result register is free
  assign out_take = !out_valid_r || out_beat.ready;
  assign s1_adv   = s1_valid_r && out_take;
  assign in_ready = !s1_valid_r || out_take;
  assign in_fire  = in_beat.valid && in_ready;
  assign in_beat.ready = in_ready;

  // Widen cursors and form candidate addresses and ends
  assign cmd     = mfbf_pkg::cmd_t'(in_beat.cmd);
  assign wp_s    = {1'b0, wp_r};
  assign rp_s    = {1'b0, rp_r};
  assign ms_s    = {1'b0, ms_r};
  assign st_addr = wp_s + mfbf_pkg::SUM_W'(in_beat.byte_index);
  assign rh_addr = rp_s + mfbf_pkg::SUM_W'(in_beat.byte_index);
  assign rc_addr = ms_s + mfbf_pkg::SUM_W'(in_beat.byte_index);
  assign adv_end = wp_s + mfbf_pkg::SUM_W'(in_beat.amount);
  assign c_end   = ms_s + mfbf_pkg::SUM_W'(in_beat.amount);

  // Head length: with nothing waiting the head is the open message
  assign wait_cnt  = mfbf_pkg::slots_waiting(ws_r, rs_r);
  assign ring_full = wait_cnt >= mfbf_pkg::SLOT_W'(mfbf_pkg::LENGTH_SLOTS - 1);
  assign head_len  = (wait_cnt == '0) ? wr_len_r : ring_r[rs_r];
  assign r_end     = rp_s + mfbf_pkg::SUM_W'(head_len);

  // Decode the command and compute the next cursor state
  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    ms_nxt     = ms_r;
    ws_nxt     = ws_r;
    rs_nxt     = rs_r;
    ov_nxt     = ov_r;
    wr_len_nxt = wr_len_r;
    ring_we    = 1'b0;
    ring_wdata = wr_len_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = st_addr[mfbf_pkg::ADDR_W-1:0];
    rd_use     = 1'b0;
    err        = 1'b0;
    do_close   = 1'b0;
    case (cmd)
      mfbf_pkg::CMD_STORE: begin
        ram_we = st_addr < mfbf_pkg::SUM_W'(mfbf_pkg::BUFFER_BYTES);
      end
      mfbf_pkg::CMD_ADVANCE: begin
        if (adv_end <= mfbf_pkg::SUM_W'(mfbf_pkg::BUFFER_BYTES)) begin
          wp_nxt     = adv_end[mfbf_pkg::PTR_W-1:0];
          wr_len_nxt = wr_len_r + in_beat.amount;
        end
      end
      mfbf_pkg::CMD_SET_OFFSET: begin
        if (c_end <= mfbf_pkg::SUM_W'(mfbf_pkg::BUFFER_BYTES)) begin
          wp_nxt     = c_end[mfbf_pkg::PTR_W-1:0];
          wr_len_nxt = in_beat.amount;
        end
      end
      mfbf_pkg::CMD_FINALIZE: begin
        do_close = 1'b1;
      end
      mfbf_pkg::CMD_CONFIRM: begin
        if (c_end == wp_s) begin
          do_close = 1'b1;
        end else if ((ms_r < wp_r && c_end > wp_s) ||
                     c_end > mfbf_pkg::SUM_W'(mfbf_pkg::BUFFER_BYTES) || ring_full) begin
          err = 1'b1;
        end else begin
          // Close the confirmed prefix; the write cursor stays
          ms_nxt     = c_end[mfbf_pkg::PTR_W-1:0];
          ring_we    = 1'b1;
          ring_wdata = in_beat.amount;
          ws_nxt     = mfbf_pkg::next_slot(ws_r);
          wr_len_nxt = '0;
        end
      end
      mfbf_pkg::CMD_READ_HEAD: begin
        ram_addr = rh_addr[mfbf_pkg::ADDR_W-1:0];
        rd_use   = rh_addr < mfbf_pkg::SUM_W'(mfbf_pkg::BUFFER_BYTES);
        ram_re   = rd_use;
      end
      mfbf_pkg::CMD_RELEASE: begin
        if (wait_cnt != '0) begin
          rs_nxt = mfbf_pkg::next_slot(rs_r);
          if (mfbf_pkg::near_end(r_end)) begin
            rp_nxt = '0;
          end else if (r_end > wp_s && rp_r < wp_r) begin
            ov_nxt = 1'b1;
            rp_nxt = wp_r;
          end else begin
            rp_nxt = r_end[mfbf_pkg::PTR_W-1:0];
          end
        end
      end
      mfbf_pkg::CMD_READ_CURRENT: begin
        ram_addr = rc_addr[mfbf_pkg::ADDR_W-1:0];
        rd_use   = rc_addr < mfbf_pkg::SUM_W'(mfbf_pkg::BUFFER_BYTES);
        ram_re   = rd_use;
      end
      default: begin
        err = 1'b0;
      end
    endcase

    // Close the open message unless the length ring is full: keep its length, wrap the cursor if needed
    if (do_close) begin
      if (ring_full) begin
        err = 1'b1;
      end else begin
        if (mfbf_pkg::near_end(wp_s)) begin
          wp_nxt = '0;
          ms_nxt = '0;
          err    = rp_r <= mfbf_pkg::PTR_W'(mfbf_pkg::MAX_MSG_BYTES);
        end else begin
          ms_nxt = wp_r;
        end
        ring_we    = 1'b1;
        ring_wdata = wr_len_r;
        ws_nxt     = mfbf_pkg::next_slot(ws_r);
        wr_len_nxt = '0;
      end
    end
  end

  // Advance cursor state on an accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r     <= '0;
      rp_r     <= '0;
      ms_r     <= '0;
      ws_r     <= '0;
      rs_r     <= '0;
      ov_r     <= 1'b0;
      wr_len_r <= '0;
    end else if (in_fire) begin
      wp_r     <= wp_nxt;
      rp_r     <= rp_nxt;
      ms_r     <= ms_nxt;
      ws_r     <= ws_nxt;
      rs_r     <= rs_nxt;
      ov_r     <= ov_nxt;
      wr_len_r <= wr_len_nxt;
    end
  end

  // Record a closed message length; each slot is written before the head reaches it
  always_ff @(posedge clk) begin
    if (in_fire && ring_we) begin
      ring_r[ws_r] <= ring_wdata;
    end
  end

  // Byte store
  mfbf_ram #(
    .WIDTH (8),
    .DEPTH (mfbf_pkg::BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (in_fire && ram_we),
    .re    (in_fire && ram_re),
    .addr  (ram_addr),
    .wdata (in_beat.data_byte),
    .rdata (ram_rdata)
  );

  // Middle stage: wait for read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_rd_use_r <= rd_use;
      s1_err_r    <= err;
    end
  end

  // Writable space at the cursor, capped, then limited by the reader
  always_comb begin
    room = '0;
    if (wp_r < mfbf_pkg::PTR_W'(mfbf_pkg::BUFFER_BYTES - 1)) begin
      room = mfbf_pkg::PTR_W'(mfbf_pkg::BUFFER_BYTES - 1) - wp_r;
    end
    if (room > mfbf_pkg::PTR_W'(mfbf_pkg::MAX_MSG_BYTES)) begin
      room = mfbf_pkg::PTR_W'(mfbf_pkg::MAX_MSG_BYTES);
    end
    if (rp_r > wp_r && (rp_r - wp_r) < mfbf_pkg::PTR_W'(mfbf_pkg::MAX_MSG_BYTES)) begin
      room = rp_r - wp_r;
    end
    space = room[7:0];
  end

  assign wait_ext = mfbf_pkg::WAIT_W'(wait_cnt);

  // Result register: status reflects the state left by this beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r  <= s1_rd_use_r ? ram_rdata : 8'd0;
      out_head_r  <= head_len;
      out_space_r <= space;
      out_wlen_r  <= wr_len_r;
      out_wait_r  <= wait_ext[3:0];
      out_err_r   <= s1_err_r;
      out_ov_r    <= ov_r;
    end
  end

  assign out_beat.valid            = out_valid_r;
  assign out_beat.data_out         = out_data_r;
  assign out_beat.head_length      = out_head_r;
  assign out_beat.write_space      = out_space_r;
  assign out_beat.write_length     = out_wlen_r;
  assign out_beat.messages_waiting = out_wait_r;
  assign out_beat.error            = out_err_r;
  assign out_beat.overtake         = out_ov_r;

  // Checks on cursor and pipeline logic
  `MFBF_ASSERT_NEXT(a_overtake_sticky, ov_r, ov_r, "overtake flag dropped")
  `MFBF_ASSERT_IMPL(a_cursor_range, 1'b1, (wp_r <= mfbf_pkg::PTR_W'(mfbf_pkg::BUFFER_BYTES)) && (rp_r <= mfbf_pkg::PTR_W'(mfbf_pkg::BUFFER_BYTES)), "cursor past buffer end")
  `MFBF_ASSERT_NEXT(a_release_empty, in_fire && cmd == mfbf_pkg::CMD_RELEASE && wait_cnt == '0, $stable(rs_r) && $stable(rp_r), "release with nothing waiting moved head")
  `MFBF_ASSERT_IMPL(a_stall_holds_input, s1_valid_r && !out_take, !in_beat.ready, "input taken while middle stage stalled")

endmodule
